[hw/rtl/ppc_pkg.sv]
// Shared types, widths and constants of the PWM period and prescaler calculator.
`default_nettype none

package ppc_pkg;

  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned TIME_W   = 27;
  localparam int unsigned TOTAL_W  = TIME_W + 1;
  localparam int unsigned SRC_W    = 31;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned PSC_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SHIFT_W  = 5;

  localparam int unsigned NUM_W = CNT_W + TIME_W;
  localparam int unsigned DEN_W = TOTAL_W;

  localparam logic [SRC_W-1:0]   SRC_CLK0     = SRC_W'(64'h0157_C000 * 64'd80);
  localparam logic [SRC_W-1:0]   SRC_CLK1     = SRC_W'(64'h0177_0000 * 64'd80);
  localparam logic [NUM_W-1:0]   TICK_RATE    = NUM_W'(80_000_000);
  localparam logic [NUM_W-1:0]   PERIOD_LIMIT = NUM_W'(1000);
  localparam logic [DEN_W-1:0]   LAST_DIV     = DEN_W'(65535);
  localparam logic [SHIFT_W-1:0] LAST_SHIFT   = SHIFT_W'(15);
  localparam logic [SHIFT_W-1:0] LAST_STEP    = SHIFT_W'(16);

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_FREQ  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FIT     = 2'd3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/pwm_period_prescaler_calc.sv]
// Top level: PWM period, prescaler and duty calculator on one shared divider.
// Each accepted request runs 1 to 21 divisions (frequency, divisor scan,
// prescaler, duty) in turn; a zero total is answered without any division.
// One item at a time: busy stays high until the result strobe.
// The single serial divider is shared by all steps; the result receiver cannot stall.
// Reset: rst_ni (async, active low) idles the sequencer and clears clock_select.
`default_nettype none

module pwm_period_prescaler_calc
  import ppc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CHAN_W-1:0]   channel_i,
  input  wire logic [TIME_W-1:0]   high_time_i,
  input  wire logic [TIME_W-1:0]   low_time_i,
  output logic                     valid_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [PSC_W-1:0]         prescaler_o,
  output logic [CNT_W-1:0]         period_count_o,
  output logic [CNT_W-1:0]         duty_count_o,
  output logic [1:0]               period_slot_o,
  output logic [CHAN_W-1:0]        duty_slot_o
);

  typedef enum logic [6:0] {
    P_IDLE = 7'b0000001,
    P_FREQ = 7'b0000010,
    P_LOOP = 7'b0000100,
    P_S65  = 7'b0001000,
    P_PSC1 = 7'b0010000,
    P_PSC2 = 7'b0100000,
    P_DUTY = 7'b1000000
  } phase_e;

  phase_e              state_q, state_d;
  logic                clk_sel_q;
  logic [SHIFT_W-1:0]  k_q, k_d, k_inc;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic [TIME_W-1:0]   hi_q, hi_d;
  logic [TOTAL_W-1:0]  total_q, total_d, total_in;
  logic [SRC_W-1:0]    src_q, src_d, src_sh;
  logic [TIME_W-1:0]   freq_q, freq_d;
  logic [CNT_W-1:0]    p_q, p_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [PSC_W-1:0]    psc_q, psc_d;
  logic [CNT_W-1:0]    duty_q, duty_d;
  logic                valid_q, valid_d;
  logic                accept;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign accept   = start && !busy;
  assign total_in = TOTAL_W'(high_time_i) + TOTAL_W'(low_time_i);
  assign k_inc    = k_q + SHIFT_W'(1);
  assign src_sh   = src_q >> k_inc;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    chan_d      = chan_q;
    hi_d        = hi_q;
    total_d     = total_q;
    src_d       = src_q;
    freq_d      = freq_q;
    p_d         = p_q;
    status_d    = status_q;
    psc_d       = psc_q;
    duty_d      = duty_q;
    valid_d     = 1'b0;
    div_req     = '0;
    unique case (state_q)
      P_IDLE: begin
        if (accept) begin
          chan_d   = channel_i;
          hi_d     = high_time_i;
          total_d  = total_in;
          src_d    = clk_sel_q ? SRC_CLK1 : SRC_CLK0;
          k_d      = '0;
          p_d      = '0;
          psc_d    = '0;
          duty_d   = '0;
          status_d = ST_OK;
          if (total_in == '0) begin
            status_d = ST_ZERO_TOTAL;
            valid_d  = 1'b1;
          end else begin
            div_req.start = 1'b1;
            div_req.num   = TICK_RATE;
            div_req.den   = total_in;
            state_d       = P_FREQ;
          end
        end
      end
      P_FREQ: begin
        if (div_rsp.done) begin
          freq_d = div_rsp.quot[TIME_W-1:0];
          if (div_rsp.quot == '0) begin
            status_d = ST_ZERO_FREQ;
            valid_d  = 1'b1;
            state_d  = P_IDLE;
          end else begin
            k_d           = k_inc;
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(src_sh);
            div_req.den   = DEN_W'(div_rsp.quot[TIME_W-1:0]);
            state_d       = P_LOOP;
          end
        end
      end
      P_LOOP: begin
        if (div_rsp.done) begin
          if (div_rsp.quot < PERIOD_LIMIT) begin
            if (div_rsp.quot == '0) begin
              status_d = ST_NO_FIT;
              valid_d  = 1'b1;
              state_d  = P_IDLE;
            end else begin
              p_d           = div_rsp.quot[CNT_W-1:0];
              div_req.start = 1'b1;
              div_req.num   = NUM_W'(src_q);
              div_req.den   = DEN_W'(freq_q);
              state_d       = P_PSC1;
            end
          end else if (k_q == LAST_STEP) begin
            status_d = ST_NO_FIT;
            valid_d  = 1'b1;
            state_d  = P_IDLE;
          end else if (k_q == LAST_SHIFT) begin
            k_d           = LAST_STEP;
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(src_q);
            div_req.den   = LAST_DIV;
            state_d       = P_S65;
          end else begin
            k_d           = k_inc;
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(src_sh);
            div_req.den   = DEN_W'(freq_q);
          end
        end
      end
      P_S65: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = div_rsp.quot;
          div_req.den   = DEN_W'(freq_q);
          state_d       = P_LOOP;
        end
      end
      P_PSC1: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          div_req.num   = div_rsp.quot;
          div_req.den   = DEN_W'(p_q);
          state_d       = P_PSC2;
        end
      end
      P_PSC2: begin
        if (div_rsp.done) begin
          psc_d         = div_rsp.quot[PSC_W-1:0] - PSC_W'(1);
          div_req.start = 1'b1;
          div_req.num   = NUM_W'(p_q) * NUM_W'(hi_q);
          div_req.den   = total_q;
          state_d       = P_DUTY;
        end
      end
      P_DUTY: begin
        if (div_rsp.done) begin
          duty_d  = div_rsp.quot[CNT_W-1:0];
          valid_d = 1'b1;
          state_d = P_IDLE;
        end
      end
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= P_IDLE;
      valid_q   <= 1'b0;
      clk_sel_q <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      k_q     <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        clk_sel_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q   <= chan_d;
    hi_q     <= hi_d;
    total_q  <= total_d;
    src_q    <= src_d;
    freq_q   <= freq_d;
    p_q      <= p_d;
    status_q <= status_d;
    psc_q    <= psc_d;
    duty_q   <= duty_d;
  end

  ppc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o    = 1'b1;
  assign busy           = (state_q != P_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign prescaler_o    = psc_q;
  assign period_count_o = p_q;
  assign duty_count_o   = duty_q;
  assign period_slot_o  = chan_q[CHAN_W-1:1];
  assign duty_slot_o    = chan_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (status_q != ST_OK) |-> (p_q == '0) && (psc_q == '0) && (duty_q == '0))
    else $error("error result with nonzero counts");

  a_ok_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (status_q == ST_OK) |-> (p_q != '0) && (p_q < CNT_W'(1000)))
    else $error("ok result with period out of range");

  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != P_IDLE) |-> div_rsp.busy || div_rsp.done)
    else $error("sequencer waits on an idle divider");

endmodule

`default_nettype wire

[hw/rtl/ppc_div.sv]
// Restoring integer divider, one quotient bit per cycle.
`default_nettype none

module ppc_div
  import ppc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned StepW = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             qbit;

  assign rem_sh = {rem_q, num_q[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_q};
  assign qbit   = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = StepW'(NUM_W);
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      num_d = {num_q[NUM_W-2:0], qbit};
      rem_d = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_d = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider restarted while running");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done longer than one cycle");

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q) && !busy_q)
    else $error("divider done without a run");

endmodule

`default_nettype wire

[tb/pwm_period_prescaler_calc_test.sv]
// Testbench for pwm_period_prescaler_calc: directed and random requests against a predictor.
`default_nettype none

module pwm_period_prescaler_calc_test;
  import ppc_pkg::*;

  localparam longint unsigned DIV_END = 65536;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PSC_W-1:0]    prescaler;
    logic [CNT_W-1:0]    period_count;
    logic [CNT_W-1:0]    duty_count;
    logic [1:0]          period_slot;
    logic [CHAN_W-1:0]   duty_slot;
  } pwm_setting_t;

  class pwm_setting_board;
    pwm_setting_t expected_settings[$];
    int errors = 0;

    function void report(string msg);
      errors++;
      if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function int pending();
      return expected_settings.size();
    endfunction

    // Work out the register settings for one accepted request.
    function void note_request(logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] hi,
                               logic [TIME_W-1:0] lo, logic clk_sel);
      longint unsigned total, src, freq, div, d, q, per;
      bit found;
      pwm_setting_t s;
      total = hi;
      total += lo;
      src = clk_sel ? SRC_CLK1 : SRC_CLK0;
      s = '0;
      s.status = ST_OK;
      if (total == 0) begin
        s.status = ST_ZERO_TOTAL;
      end else begin
        freq = TICK_RATE / total;
        if (freq == 0) begin
          s.status = ST_ZERO_FREQ;
        end else begin
          per = 0;
          found = 0;
          for (div = 2; div <= DIV_END && !found; div <<= 1) begin
            d = (div == DIV_END) ? longint'(LAST_DIV) : div;
            q = src / d / freq;
            if (q < PERIOD_LIMIT) begin
              per = q;
              found = 1;
            end
          end
          if (per == 0) begin
            s.status = ST_NO_FIT;
          end else begin
            s.prescaler    = PSC_W'(src / freq / per - 1);
            s.period_count = CNT_W'(per);
            s.duty_count   = CNT_W'(per * hi / total);
          end
        end
      end
      s.period_slot = ch[CHAN_W-1:1];
      s.duty_slot   = ch;
      expected_settings.push_back(s);
    endfunction

    function void check_field(string name, longint got, longint exp, bit bad);
      if (bad) report($sformatf("%s got %0d expected %0d", name, got, exp));
    endfunction

    function void check_setting(pwm_setting_t got);
      pwm_setting_t exp;
      if (expected_settings.size() == 0) begin
        report("result with no request pending");
        return;
      end
      exp = expected_settings.pop_front();
      check_field("status", got.status, exp.status, got.status !== exp.status);
      check_field("prescaler", got.prescaler, exp.prescaler,
                  got.prescaler !== exp.prescaler);
      check_field("period_count", got.period_count, exp.period_count,
                  got.period_count !== exp.period_count);
      check_field("duty_count", got.duty_count, exp.duty_count,
                  got.duty_count !== exp.duty_count);
      check_field("period_slot", got.period_slot, exp.period_slot,
                  got.period_slot !== exp.period_slot);
      check_field("duty_slot", got.duty_slot, exp.duty_slot,
                  got.duty_slot !== exp.duty_slot);
    endfunction

    function void check_drained();
      if (expected_settings.size() != 0)
        report($sformatf("%0d results never arrived", expected_settings.size()));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_data_i;
  logic                start;
  logic                busy;
  logic [CHAN_W-1:0]   channel_i;
  logic [TIME_W-1:0]   high_time_i;
  logic [TIME_W-1:0]   low_time_i;
  logic                valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [PSC_W-1:0]    prescaler_o;
  logic [CNT_W-1:0]    period_count_o;
  logic [CNT_W-1:0]    duty_count_o;
  logic [1:0]          period_slot_o;
  logic [CHAN_W-1:0]   duty_slot_o;

  pwm_setting_board sb;
  logic clk_sel;
  bit gaps_on;

  pwm_period_prescaler_calc i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .channel_i      (channel_i),
    .high_time_i    (high_time_i),
    .low_time_i     (low_time_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .prescaler_o    (prescaler_o),
    .period_count_o (period_count_o),
    .duty_count_o   (duty_count_o),
    .period_slot_o  (period_slot_o),
    .duty_slot_o    (duty_slot_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_setting('{status_o, prescaler_o, period_count_o, duty_count_o,
                         period_slot_o, duty_slot_o});
    end
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(99, 0);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(4, 1);
    return $urandom_range(900, 5);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_request(logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] hi,
                              logic [TIME_W-1:0] lo);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start       = 1'b0;
      channel_i   = CHAN_W'($urandom);
      high_time_i = TIME_W'($urandom);
      low_time_i  = TIME_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    start       = 1'b1;
    channel_i   = ch;
    high_time_i = hi;
    low_time_i  = lo;
    do @(posedge clk_i); while (busy);
    sb.note_request(ch, hi, lo, clk_sel);
    @(negedge clk_i);
  endtask

  task automatic write_clock_select(logic v);
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    clk_sel = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_request();
    int unsigned total;
    int k;
    logic [TIME_W-1:0] hi, lo;
    case ($urandom_range(9, 0))
      0: begin
        hi = TIME_W'($urandom);
        lo = TIME_W'($urandom);
      end
      1: begin
        hi = TIME_W'($urandom_range(3, 0));
        lo = TIME_W'($urandom_range(3, 0));
      end
      default: begin
        // log-uniform total: spans fitting, no-fit and zero-frequency requests
        k = $urandom_range(27, 1);
        total = $urandom_range((1 << k) - 1, 1 << (k - 1));
        hi = TIME_W'($urandom_range(total, 0));
        lo = TIME_W'(total - hi);
      end
    endcase
    send_request(CHAN_W'($urandom), hi, lo);
  endtask

  initial begin
    int n;
    sb          = new();
    clk_sel     = 1'b0;
    gaps_on     = 1'b1;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    start       = 1'b0;
    channel_i   = '0;
    high_time_i = '0;
    low_time_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_clock_select(1'b0);
    send_request(3'd0, 27'd0, 27'd0);
    send_request(3'd7, 27'd1, 27'd0);
    send_request(3'd1, 27'd0, 27'd1);
    send_request(3'd2, 27'd1, 27'd1);
    send_request(3'd3, 27'd250, 27'd750);
    send_request(3'd4, 27'h7FFFFFF, 27'd0);
    send_request(3'd5, 27'd0, 27'h7FFFFFF);
    send_request(3'd6, 27'h7FFFFFF, 27'h7FFFFFF);
    send_request(3'd7, 27'd40000000, 27'd40000000);
    send_request(3'd0, 27'd40000000, 27'd40000001);
    send_request(3'd1, 27'd80000000, 27'd0);
    send_request(3'd2, 27'd1000000, 27'd1857142);
    send_request(3'd3, 27'd1000000, 27'd1857143);
    send_request(3'd4, 27'd87, 27'd1);
    send_request(3'd5, 27'd12345, 27'd54321);

    write_clock_select(1'b1);
    send_request(3'd6, 27'd0, 27'd0);
    send_request(3'd7, 27'd1, 27'd0);
    send_request(3'd0, 27'd2580645, 27'd0);
    send_request(3'd1, 27'd2580646, 27'd0);
    send_request(3'd2, 27'd80000000, 27'd1);
    send_request(3'd3, 27'd333, 27'd4444);
    send_request(3'd4, 27'h5555555, 27'h2AAAAAA);

    for (int phase = 0; phase < 6; phase++) begin
      write_clock_select(phase[0]);
      gaps_on = (phase != 2);
      repeat (125) random_request();
    end
    start = 1'b0;

    for (n = 0; n < 5000 && sb.pending() != 0; n++) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #25000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
